// ----- src/vwq_pkg.sv -----
// ----------------------------------------------------------------------------
// vwq_pkg
// shared types and constants of the visual word quantizer and its cell chain
// ----------------------------------------------------------------------------
package vwq_pkg;

  localparam int DIST_W  = 23;
  localparam int CNT_W   = 16;
  localparam int WORD_W  = 6;
  localparam int NWIN_W  = 7;

  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

  // input actions
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_FEATURE = 2'd1;
  localparam logic [1:0] ACT_EMIT    = 2'd2;

  // result kinds
  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_HIST = 1'b1;

  // register map, selected by address bit 2
  localparam logic              REG_WORDS_IN_USE = 1'b0;
  localparam logic [NWIN_W-1:0] WORDS_IN_USE_RST = 7'd16;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         centroid_index;
    logic [6:0]         element_index;
    logic signed [15:0] element_value;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  count;
    logic [DIST_W-1:0] distance;
    logic              last;
  } out_item_t;

  // running best handed from cell to cell during the search
  typedef struct packed {
    logic              has;
    logic [DIST_W-1:0] best_dist;
    logic [WORD_W-1:0] idx;
    logic [CNT_W-1:0]  cnt;
  } tok_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic load;
    logic rd;
    logic acc;
    logic clr_acc;
    logic bump;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SEARCH,
    ST_RESULT,
    ST_EMIT
  } state_t;

endpackage

// ----- src/visual_word_quantizer_histogram_top.sv -----
// ----------------------------------------------------------------------------
// visual_word_quantizer_histogram_top
// a word item follows the final feature element through the accumulate stage,
//   the start state, the search wave through the cell chain and the result state;
//   histogram items follow an emit item, one bin per cycle unless the output stalls
// throughput: load and non-final feature elements one per cycle; a final element
//   holds the input until its word is out, an emit until the last bin has shifted
// reset: synchronous; accumulators, counters and control clear, centroid store undefined
// ----------------------------------------------------------------------------
module visual_word_quantizer_histogram_top
  import vwq_pkg::*;
#(
  parameter int NUM_WORDS  = 16,
  parameter int DIMS       = 128,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int IW = $clog2(NUM_WORDS);
  localparam logic [NWIN_W-1:0] NW_LIM   = NWIN_W'(NUM_WORDS);
  localparam logic [7:0]        DIMS_LIM = 8'(DIMS);
  localparam logic [IW-1:0]     IDX_LAST = IW'(NUM_WORDS - 1);

  // configuration register
  logic [NWIN_W-1:0] words_in_use_r;
  logic [NWIN_W-1:0] n_eff;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                   && (cfg_paddr[2] == REG_WORDS_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_in_use_r <= WORDS_IN_USE_RST;
    end else if (cfg_wr) begin
      words_in_use_r <= cfg_pwdata[NWIN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_WORDS_IN_USE) begin
      cfg_prdata = {{(32-NWIN_W){1'b0}}, words_in_use_r};
    end
  end

  // zero acts as one, anything above the cell count as the cell count
  always_comb begin
    n_eff = words_in_use_r;
    if (words_in_use_r == '0) begin
      n_eff = NWIN_W'(1);
    end else if (words_in_use_r > NW_LIM) begin
      n_eff = NW_LIM;
    end
  end

  // element value as stored: low bits sign-taken, or zero-extended when wider
  logic [VALUE_BITS-1:0] in_value;
  generate
    if (VALUE_BITS <= 16) begin : g_narrow
      assign in_value = in_item.element_value[VALUE_BITS-1:0];
    end else begin : g_wide
      assign in_value = {{(VALUE_BITS-16){1'b0}}, in_item.element_value};
    end
  endgenerate

  state_t state_r, state_nxt;
  logic   in_fire, out_free;
  logic   ei_ok, ci_ok;

  assign in_fire  = in_valid && in_ready;
  assign ei_ok    = ({1'b0, in_item.element_index} < DIMS_LIM);
  assign ci_ok    = ({1'b0, in_item.centroid_index} < NW_LIM);

  // accumulate stage: the store read lands here in the cycle after accept
  logic                  s1_valid_r, s1_inrange_r, s1_last_r;
  logic [VALUE_BITS-1:0] s1_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire && (in_item.action == ACT_FEATURE);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_inrange_r <= ei_ok;
      s1_last_r    <= in_item.last_element;
      s1_value_r   <= in_value;
    end
  end

  // a final element blocks intake until its word has been produced
  assign in_ready = (state_r == ST_IDLE) && !(s1_valid_r && s1_last_r);

  // cell chain
  cell_ctrl_t        ctrl;
  logic              tok_vld_w [NUM_WORDS+1];
  tok_t              tok_w     [NUM_WORDS+1];
  logic [CNT_W-1:0]  cnt_w     [NUM_WORDS+1];
  logic [NUM_WORDS-1:0] nz;
  logic              tok_start;
  logic [WORD_W-1:0] bump_idx;

  assign tok_vld_w[0]      = tok_start;
  assign tok_w[0]          = '0;
  assign cnt_w[NUM_WORDS]  = '0;

  generate
    for (genvar i = 0; i < NUM_WORDS; i++) begin : g_cell
      vwq_cell #(
        .IDX        (i),
        .DIMS       (DIMS),
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .n_active    (n_eff),
        .wr_cidx     (in_item.centroid_index),
        .addr        (in_item.element_index[AW-1:0]),
        .wr_data     (in_value),
        .feat_value  (s1_value_r),
        .bump_idx    (bump_idx),
        .tok_vld_in  (tok_vld_w[i]),
        .tok_in      (tok_w[i]),
        .tok_vld_out (tok_vld_w[i+1]),
        .tok_out     (tok_w[i+1]),
        .cnt_in      (cnt_w[i+1]),
        .cnt_out     (cnt_w[i])
      );
      assign nz[i] = |cnt_w[i];
    end
  endgenerate

  // winner of the search, as it leaves the last cell
  tok_t tok_end;
  assign tok_end  = tok_w[NUM_WORDS];
  assign bump_idx = tok_end.idx;

  // output register
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      out_load;
  logic [IW-1:0] emit_idx_r, emit_idx_nxt;

  assign out_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    emit_idx_nxt = emit_idx_r;
    tok_start    = 1'b0;
    out_load     = 1'b0;
    out_item_nxt = out_item_r;
    ctrl         = '0;
    ctrl.load    = in_fire && (in_item.action == ACT_LOAD) && ei_ok && ci_ok;
    ctrl.rd      = in_fire && (in_item.action == ACT_FEATURE);
    ctrl.acc     = s1_valid_r && s1_inrange_r;

    unique case (state_r)
      ST_IDLE: begin
        if (s1_valid_r && s1_last_r) begin
          state_nxt = ST_START;
        end else if (in_fire && (in_item.action == ACT_EMIT)) begin
          emit_idx_nxt = '0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_START: begin
        // launch the search wave into cell 0
        tok_start = 1'b1;
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tok_vld_w[NUM_WORDS]) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_item_nxt.kind     = KIND_WORD;
          out_item_nxt.word     = tok_end.idx;
          out_item_nxt.count    = (tok_end.cnt == COUNT_MAX) ? COUNT_MAX
                                                             : tok_end.cnt + 1'b1;
          out_item_nxt.distance = tok_end.best_dist;
          out_item_nxt.last     = 1'b0;
          ctrl.bump             = 1'b1;
          ctrl.clr_acc          = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // counters shift down one cell a cycle while the output can take the bin; zero bins pass without waiting
        if (out_free || !nz[0]) begin
          ctrl.shift = 1'b1;
          if (nz[0]) begin
            out_load              = 1'b1;
            out_item_nxt.kind     = KIND_HIST;
            out_item_nxt.word     = WORD_W'(emit_idx_r);
            out_item_nxt.count    = cnt_w[0];
            out_item_nxt.distance = '0;
            out_item_nxt.last     = ~|nz[NUM_WORDS-1:1];
          end
          if (emit_idx_r == IDX_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      emit_idx_r <= emit_idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a final element always starts the search
  a_last_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && s1_valid_r && s1_last_r |=> state_r == ST_START)
    else $error("final element did not start the search");

  // the wave only leaves the chain while the sequencer waits for it
  a_wave_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_vld_w[NUM_WORDS] |-> state_r == ST_SEARCH)
    else $error("search wave left the chain outside the search");

  // a word item never carries the end-of-run mark
  a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.kind == KIND_WORD) |-> !out_item_r.last)
    else $error("word item marked last");

  // the chosen word is one of the active centroids
  a_word_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.kind == KIND_WORD) |-> {1'b0, out_item_r.word} < n_eff)
    else $error("word item names an inactive centroid");

endmodule

// ----- src/vwq_cell.sv -----
// ----------------------------------------------------------------------------
// vwq_cell
// one centroid: element store, l1 accumulator, word counter, search stage
// ----------------------------------------------------------------------------
module vwq_cell
  import vwq_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int DIMS       = 128,
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctrl_t            ctrl,
  input  logic [NWIN_W-1:0]     n_active,
  input  logic [WORD_W-1:0]     wr_cidx,
  input  logic [((DIMS > 1) ? $clog2(DIMS) : 1)-1:0] addr,
  input  logic [VALUE_BITS-1:0] wr_data,
  input  logic [VALUE_BITS-1:0] feat_value,
  input  logic [WORD_W-1:0]     bump_idx,
  input  logic                  tok_vld_in,
  input  tok_t                  tok_in,
  output logic                  tok_vld_out,
  output tok_t                  tok_out,
  input  logic [CNT_W-1:0]      cnt_in,
  output logic [CNT_W-1:0]      cnt_out
);

  localparam int SUM_W = ((VALUE_BITS + 1 > DIST_W) ? VALUE_BITS + 1 : DIST_W) + 1;
  localparam logic [SUM_W-1:0] SUM_SAT = SUM_W'(DIST_MAX);

  logic [VALUE_BITS-1:0] mem [DIMS];
  logic [VALUE_BITS-1:0] rd_q_r;
  logic [DIST_W-1:0]     acc_r, acc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  tok_vld_r;
  tok_t                  tok_r, tok_nxt;

  logic                     active;
  logic signed [VALUE_BITS:0] diff;
  logic [VALUE_BITS:0]      absd;
  logic [SUM_W-1:0]         sum;
  logic                     take;

  assign active = (NWIN_W'(IDX) < n_active);

  // centroid elements
  always_ff @(posedge clk) begin
    if (ctrl.load && (wr_cidx == WORD_W'(IDX))) begin
      mem[addr] <= wr_data;
    end
    if (ctrl.rd) begin
      rd_q_r <= mem[addr];
    end
  end

  // saturating l1 accumulation
  always_comb begin
    diff = $signed({feat_value[VALUE_BITS-1], feat_value})
         - $signed({rd_q_r[VALUE_BITS-1], rd_q_r});
    absd = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);
    sum  = SUM_W'(acc_r) + SUM_W'(absd);
    acc_nxt = acc_r;
    if (ctrl.clr_acc) begin
      acc_nxt = '0;
    end else if (ctrl.acc && active) begin
      acc_nxt = (sum > SUM_SAT) ? DIST_MAX : DIST_W'(sum);
    end
  end

  // counter: bumped on a win, shifted towards cell 0 on emit
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.shift) begin
      cnt_nxt = cnt_in;
    end else if (ctrl.bump && (bump_idx == WORD_W'(IDX)) && (cnt_r != COUNT_MAX)) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // strict compare so the lower index keeps ties
  always_comb begin
    take    = active && (!tok_in.has || (acc_r < tok_in.best_dist));
    tok_nxt = tok_in;
    tok_nxt.has = tok_in.has | active;
    if (take) begin
      tok_nxt.best_dist = acc_r;
      tok_nxt.idx       = WORD_W'(IDX);
      tok_nxt.cnt       = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      cnt_r     <= '0;
      tok_vld_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      tok_vld_r <= tok_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_vld_in) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_vld_out = tok_vld_r;
  assign tok_out     = tok_r;
  assign cnt_out     = cnt_r;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the visual word quantizer: a directed table run with
// a single active word, a codebook fill, then randomised phases at several word
// counts; each result is checked against the table or a codebook model in the bench
// ----------------------------------------------------------------------------
module tb_top;
  import vwq_pkg::*;

  localparam int NW          = 16;
  localparam int DIM         = 128;
  localparam int SETTLE      = NW + 8;     // search wave plus margin
  localparam int DRAIN_LIMIT = 20000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 15;

  // action code the block ignores
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  // register map: bit 2 of the address picks the register
  localparam logic [2:0] ADDR_WORDS_IN_USE = {REG_WORDS_IN_USE, 2'b00};
  localparam logic [2:0] ADDR_SPARE        = {~REG_WORDS_IN_USE, 2'b00};

  // q8.8 extremes
  localparam logic signed [15:0] VAL_MAX = 16'sh7fff;
  localparam logic signed [15:0] VAL_MIN = 16'sh8000;

  // how a table row gets its expected results
  localparam int PREDICTED  = -1;
  localparam int NO_RESULT  = 0;
  localparam int ONE_RESULT = 1;

  typedef struct {
    in_item_t  item;
    int        repeats;
    int        typed_n;
    out_item_t typed_res;
  } stim_row_t;

  // ports
  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  in_item_t    in_item     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  out_item_t   out_item;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // codebook model state
  int                cb_value   [NW][DIM];
  bit                cb_written [NW][DIM];
  int                l1_sum     [NW];
  int                word_hits  [NW];
  logic [NWIN_W-1:0] words_reg = WORDS_IN_USE_RST;

  out_item_t step_results [$];   // results of the item just accepted
  out_item_t due_results  [$];   // results still to come out, oldest first
  stim_row_t plan         [$];
  int        ready_cols   [$];   // columns filled for every centroid

  bit gaps_on     = 1'b1;
  int fault_count = 0;
  int cycle_count = 0;
  int out_hold    = 0;

  visual_word_quantizer_histogram_top #(
    .NUM_WORDS  (NW),
    .DIMS       (DIM),
    .VALUE_BITS (16)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --

  // register value clamped to the range the block honours
  function automatic int active_words();
    int n;
    n = int'(words_reg);
    if (n < 1) n = 1;
    if (n > NW) n = NW;
    return n;
  endfunction

  // applies one item to the codebook model, leaving its results in step_results
  function automatic void codebook_step(input in_item_t it);
    int        i, n, ci, ei, d, s, best;
    out_item_t res;
    step_results.delete();
    ci = int'(it.centroid_index);
    ei = int'(it.element_index);
    n  = active_words();
    case (it.action)
      ACT_LOAD: begin
        // out-of-range centroid or position: write dropped
        if (ci < NW && ei < DIM) begin
          cb_value[ci][ei]   = int'(it.element_value);
          cb_written[ci][ei] = 1'b1;
        end
      end
      ACT_FEATURE: begin
        if (ei < DIM) begin
          for (i = 0; i < n; i++) begin
            d = int'(it.element_value) - cb_value[i][ei];
            if (d < 0) d = -d;
            s = l1_sum[i] + d;
            l1_sum[i] = (s > int'(DIST_MAX)) ? int'(DIST_MAX) : s;
          end
        end
        if (it.last_element) begin
          // strict compare, so the lower index keeps a tie
          best = 0;
          for (i = 1; i < n; i++)
            if (l1_sum[i] < l1_sum[best]) best = i;
          if (word_hits[best] < int'(COUNT_MAX)) word_hits[best]++;
          res          = '0;
          res.kind     = KIND_WORD;
          res.word     = WORD_W'(best);
          res.count    = CNT_W'(word_hits[best]);
          res.distance = DIST_W'(l1_sum[best]);
          res.last     = 1'b0;
          step_results = {step_results, res};
          for (i = 0; i < NW; i++) l1_sum[i] = 0;
        end
      end
      ACT_EMIT: begin
        for (i = 0; i < NW; i++) begin
          if (word_hits[i] != 0) begin
            res          = '0;
            res.kind     = KIND_HIST;
            res.word     = WORD_W'(i);
            res.count    = CNT_W'(word_hits[i]);
            step_results = {step_results, res};
          end
        end
        if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
        for (i = 0; i < NW; i++) word_hits[i] = 0;
      end
      default: ;  // unused action code
    endcase
  endfunction

  // ------------------------------------------------------------- stimulus --

  function automatic in_item_t mk_item(input logic [1:0] act, input int ci, input int ei,
                                       input logic signed [15:0] v, input bit lst);
    in_item_t it;
    it.action         = act;
    it.centroid_index = 6'(ci);
    it.element_index  = 7'(ei);
    it.element_value  = v;
    it.last_element   = lst;
    return it;
  endfunction

  function automatic out_item_t word_res(input int w, input int cnt, input int dist_val);
    out_item_t r;
    r          = '0;
    r.kind     = KIND_WORD;
    r.word     = WORD_W'(w);
    r.count    = CNT_W'(cnt);
    r.distance = DIST_W'(dist_val);
    return r;
  endfunction

  function automatic out_item_t hist_res(input int w, input int cnt, input bit lst);
    out_item_t r;
    r       = '0;
    r.kind  = KIND_HIST;
    r.word  = WORD_W'(w);
    r.count = CNT_W'(cnt);
    r.last  = lst;
    return r;
  endfunction

  function automatic void add_row(input in_item_t it, input int repeats, input int typed_n,
                                  input out_item_t res);
    stim_row_t row;
    row.item      = it;
    row.repeats   = repeats;
    row.typed_n   = typed_n;
    row.typed_res = res;
    plan = {plan, row};
  endfunction

  // biased towards the q8.8 extremes and zero
  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(7, 0))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // a position that every active centroid has had written
  function automatic int pick_column();
    int col, n, i, tries;
    bit ok;
    n = active_words();
    for (tries = 0; tries < 8; tries++) begin
      col = int'($urandom_range(DIM - 1, 0));
      ok  = 1'b1;
      for (i = 0; i < n; i++)
        if (!cb_written[i][col]) ok = 1'b0;
      if (ok) return col;
    end
    return ready_cols[$urandom_range(ready_cols.size() - 1, 0)];
  endfunction

  // offers one item, optionally after an idle burst, and books its results
  task automatic send_item(input in_item_t it, input int typed_n, input out_item_t typed_res);
    if (gaps_on && $urandom_range(7, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    codebook_step(it);
    if (typed_n == PREDICTED) begin
      due_results = {due_results, step_results};
    end else if (typed_n == ONE_RESULT) begin
      due_results = {due_results, typed_res};
    end
  endtask

  // one apb transfer; psel is left high so transfers can run back to back
  task automatic cfg_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) begin
      if (addr[2] == REG_WORDS_IN_USE) words_reg = data[NWIN_W-1:0];
    end else if (cfg_prdata !== {{(32 - NWIN_W){1'b0}}, words_reg}) begin
      $display("%0t: words_in_use readback mismatch, expected %0d, got %0h",
               $time, words_reg, cfg_prdata);
      fault_count++;
    end
  endtask

  // write with junk in the upper bits, read back, release the bus
  task automatic set_words_in_use(input logic [NWIN_W-1:0] v);
    cfg_access(1'b1, ADDR_WORDS_IN_USE, {(32 - NWIN_W)'($urandom), v});
    cfg_access(1'b0, ADDR_WORDS_IN_USE, '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // waits for every booked result, then lets the search wave die out
  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // ------------------------------------------------------------- checking --

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    fault_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      $display("%0t: result %h with nothing awaited", $time, got);
      fault_count++;
    end else begin
      want = due_results.pop_front();
      if (got.kind !== want.kind)         report_field("kind", want.kind, got.kind);
      if (got.word !== want.word)         report_field("word", want.word, got.word);
      if (got.count !== want.count)       report_field("count", want.count, got.count);
      if (got.distance !== want.distance) report_field("distance", want.distance, got.distance);
      if (got.last !== want.last)         report_field("last", want.last, got.last);
    end
  endtask

  // result sampling plus random bursts of receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_item);
    if (out_hold > 0) begin
      out_hold = out_hold - 1;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(9, 0) == 0) begin
      out_hold = $urandom_range(9, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("tb_top failed");
      $finish;
    end
  end

  // ------------------------------------------------------------- sequence --

  initial begin
    int                       p, k, c, len, pick, sent;
    logic signed [15:0]       pool [3];
    logic [NWIN_W-1:0]        phase_words [6];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs with words_in_use 0, so only centroid 0 is searched
    set_words_in_use('0);

    // nothing counted yet, and the unused action code
    add_row(mk_item(ACT_EMIT, 0, 0, '0, 1'b0), 1, NO_RESULT, '0);
    add_row(mk_item(ACT_IGNORED, 63, 127, 16'shffff, 1'b1), 1, NO_RESULT, '0);
    // centroid 0 at both ends of the vector
    add_row(mk_item(ACT_LOAD, 0, 0, VAL_MAX, 1'b0), 1, NO_RESULT, '0);
    add_row(mk_item(ACT_LOAD, 0, DIM - 1, VAL_MIN, 1'b1), 1, NO_RESULT, '0);
    // centroid indexes past the store must not alias onto centroid 0
    add_row(mk_item(ACT_LOAD, NW, 0, '0, 1'b0), 1, NO_RESULT, '0);
    add_row(mk_item(ACT_LOAD, 63, 0, 16'shffff, 1'b0), 1, NO_RESULT, '0);
    // largest single-element distance, then two of them summed
    add_row(mk_item(ACT_FEATURE, 63, 0, VAL_MIN, 1'b1), 1, ONE_RESULT, word_res(0, 1, 65535));
    add_row(mk_item(ACT_FEATURE, 0, DIM - 1, VAL_MAX, 1'b0), 1, NO_RESULT, '0);
    add_row(mk_item(ACT_FEATURE, 0, 0, VAL_MIN, 1'b1), 1, ONE_RESULT, word_res(0, 2, 131070));
    add_row(mk_item(ACT_FEATURE, 0, 0, VAL_MAX, 1'b1), 1, ONE_RESULT, word_res(0, 3, 0));
    // one bin, then an empty histogram after the clear
    add_row(mk_item(ACT_EMIT, 63, DIM - 1, VAL_MIN, 1'b1), 1, ONE_RESULT, hist_res(0, 3, 1'b1));
    add_row(mk_item(ACT_EMIT, 0, 0, '0, 1'b0), 1, NO_RESULT, '0);

    // long repeated rows run without idling to keep the run short
    foreach (plan[r]) begin
      gaps_on = (plan[r].repeats == 1);
      repeat (plan[r].repeats) send_item(plan[r].item, plan[r].typed_n, plan[r].typed_res);
    end
    gaps_on = 1'b1;

    // codebook fill: a few columns for every centroid, values from a small
    // pool per column so that equal distances and ties turn up often
    drain();
    set_words_in_use(7'(NW));
    ready_cols = {ready_cols, 0};
    ready_cols = {ready_cols, DIM - 1};
    ready_cols = {ready_cols, int'($urandom_range(DIM - 2, 1))};
    foreach (ready_cols[q]) begin
      for (k = 0; k < 3; k++) pool[k] = rand_value();
      for (c = 0; c < NW; c++)
        send_item(mk_item(ACT_LOAD, c, ready_cols[q], pool[$urandom_range(2, 0)],
                          1'($urandom_range(1, 0))), PREDICTED, '0);
    end

    // random phases; last one with no idling on either side
    phase_words = '{7'(NW), 7'd127, 7'd1, 7'd64, 7'($urandom_range(NW - 1, 2)), 7'(NW)};
    for (p = 0; p < 6; p++) begin
      drain();
      gaps_on = (p != 5);
      if (p == 0) cfg_access(1'b1, ADDR_SPARE, $urandom);  // unmapped, no effect
      set_words_in_use(phase_words[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99, 0);
        if (pick < 55) begin
          // well-formed descriptor of 1 to 4 elements
          len = $urandom_range(4, 1);
          for (k = 0; k < len; k++)
            send_item(mk_item(ACT_FEATURE, $urandom_range(63, 0), pick_column(), rand_value(),
                              k == len - 1), PREDICTED, '0);
          sent += len;
        end else if (pick < 80) begin
          // mostly real centroids, sometimes past the store
          send_item(mk_item(ACT_LOAD,
                            ($urandom_range(3, 0) == 0) ? $urandom_range(63, 0)
                                                        : $urandom_range(NW - 1, 0),
                            $urandom_range(DIM - 1, 0), rand_value(),
                            1'($urandom_range(1, 0))),
                    PREDICTED, '0);
          sent++;
        end else if (pick < 92) begin
          send_item(mk_item(ACT_EMIT, $urandom_range(63, 0), $urandom_range(DIM - 1, 0),
                            16'($urandom), 1'($urandom_range(1, 0))), PREDICTED, '0);
          sent++;
        end else begin
          // noise, not counted
          send_item(mk_item(ACT_IGNORED, $urandom_range(63, 0), $urandom_range(DIM - 1, 0),
                            16'($urandom), 1'($urandom_range(1, 0))), PREDICTED, '0);
        end
      end
    end

    drain();
    if (due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_results.size());
      fault_count++;
    end
    if (fault_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
